// ----- src/sokd_pkg.sv -----
// Shared constants and types for the stochastic oscillator (%K / %D) block.
// No dependencies; imported by every module of the block.
package sokd_pkg;

    localparam int MAX_K_DEF = 64;
    localparam int MAX_D_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF = 24;

    // Width of a percentage in Q7.8 and of every quotient of the divider.
    localparam int PCT_W = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
    localparam logic [PCT_W-1:0] PCT_HALF = 15'd12800;

    localparam logic [6:0] K_PERIOD_RST = 7'd14;
    localparam logic [4:0] D_PERIOD_RST = 5'd3;
    localparam logic [6:0] MIN_SAMPLES_RST = 7'd0;
    localparam logic [PCT_W-1:0] OB_LEVEL_RST = 15'd20480;
    localparam logic [PCT_W-1:0] OS_LEVEL_RST = 15'd5120;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_K_PERIOD    = 3'd0,
        REG_D_PERIOD    = 3'd1,
        REG_MIN_SAMPLES = 3'd2,
        REG_OB_LEVEL    = 3'd3,
        REG_OS_LEVEL    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CROSS_NONE = 2'd0,
        CROSS_UP   = 2'd1,
        CROSS_DOWN = 2'd2
    } cross_t;

endpackage

// ----- src/stochastic_oscillator_kd.sv -----
// Stochastic oscillator top level: control sequencer, configuration and results.
// Depends on sokd_pkg, sokd_window, sokd_hist and sokd_div.
//
// Usage: samples arrive on the in_valid/in_ready request channel, one result
// per sample leaves on out_valid/out_ready. Registers are written through
// cfg_we/cfg_index/cfg_data; any write to a known index clears all state
// and counters. Write configuration only while no sample is in flight.
//
// Steps per sample: store it in the window memory; if the block is ready,
// scan the filled window entries (one memory read per cycle), launch the
// %K division unless the window is flat, run it in the serial divider, do
// the %K history read-modify-write, run the %D division once the history is
// full, and post the result. Before the block is ready a sample is only
// stored and posted. A new sample is taken only after the last result is posted.
// The window scan and the shared divider set the rate.
//
// Reset clears the configuration to its defaults and all control state. A result
// waits in the output register while out_ready is low; the next sample is
// taken, but its result is held back until the register is free.
module stochastic_oscillator_kd #(
    parameter int MAX_K_PERIOD = sokd_pkg::MAX_K_DEF,
    parameter int MAX_D_PERIOD = sokd_pkg::MAX_D_DEF,
    parameter int SAMPLE_WIDTH = sokd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                ready_res,
    output logic [sokd_pkg::PCT_W-1:0]          k_pct,
    output logic                                d_valid,
    output logic [sokd_pkg::PCT_W-1:0]          d_pct,
    output logic                                overbought,
    output logic                                oversold,
    output logic                                overbought_event,
    output logic                                oversold_event,
    output logic [1:0]                          crossing,
    output logic [31:0]                         sample_count,
    output logic [31:0]                         overbought_count,
    output logic [31:0]                         oversold_count,
    input  logic                                cfg_we,
    input  logic [sokd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sokd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sokd_pkg::*;

    localparam int KW    = $clog2(MAX_K_PERIOD + 1);
    localparam int KAW   = $clog2(MAX_K_PERIOD);
    localparam int NW    = (KW > 7) ? KW : 7;
    localparam int DW    = $clog2(MAX_D_PERIOD + 1);
    localparam int DAW   = (MAX_D_PERIOD > 1) ? $clog2(MAX_D_PERIOD) : 1;
    localparam int KSW   = $clog2(MAX_D_PERIOD * 25600 + 1);
    localparam int DEN_W = SAMPLE_WIDTH + 1;
    localparam int NUM_W = DEN_W + PCT_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WRITE = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_DIVK  = 9'b000010000,
        S_HREAD = 9'b000100000,
        S_HUPD  = 9'b001000000,
        S_DIVD  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]       k_period_reg;
    logic [4:0]       d_period_reg;
    logic [6:0]       min_samples_reg;
    logic [PCT_W-1:0] ob_level_reg;
    logic [PCT_W-1:0] os_level_reg;

    logic [KAW-1:0]   head_reg;
    logic [KW-1:0]    fill_reg;
    logic [DAW-1:0]   hhead_reg;
    logic [DW-1:0]    hfill_reg;
    logic [KSW-1:0]   ksum_reg;
    logic             dready_reg;
    logic [PCT_W-1:0] lastd_reg;
    logic             was_ob_reg;
    logic             was_os_reg;
    logic             was_above_reg;
    logic [31:0]      total_reg;
    logic [31:0]      ob_total_reg;
    logic [31:0]      os_total_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [PCT_W-1:0] kp_reg;
    logic             item_ready_reg;
    logic [DEN_W-1:0] range_reg;
    logic [DEN_W-1:0] diff_reg;

    logic             out_valid_reg;
    logic             ready_res_reg;
    logic [PCT_W-1:0] k_pct_reg;
    logic             d_valid_reg;
    logic [PCT_W-1:0] d_pct_reg;
    logic             ob_reg;
    logic             os_reg;
    logic             ob_ev_reg;
    logic             os_ev_reg;
    logic [1:0]       cross_reg;
    logic [31:0]      cnt_s_reg;
    logic [31:0]      cnt_ob_reg;
    logic [31:0]      cnt_os_reg;

    logic [KW-1:0]    k_used;
    logic [DW-1:0]    d_used;
    logic [NW-1:0]    need;
    logic [KAW-1:0]   head_eff;
    logic [KAW-1:0]   head_nx;
    logic [KW-1:0]    fill_nx;
    logic [DAW-1:0]   hhead_eff;
    logic [DAW-1:0]   hhead_nx;
    logic [DW-1:0]    hfill_nx;
    logic [KSW-1:0]   ksum_nx;
    logic [PCT_W-1:0] hist_old;
    logic             cfg_clear;
    logic             accept_in;
    logic             slot_free;
    logic             scan_done;
    logic signed [SAMPLE_WIDTH-1:0] win_hi;
    logic signed [SAMPLE_WIDTH-1:0] win_lo;
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [PCT_W-1:0] div_quot;
    logic             ob_now;
    logic             os_now;
    logic             above_now;
    logic             ob_ev_now;
    logic             os_ev_now;
    cross_t           cross_now;

    always_comb
    begin
        if (k_period_reg < 7'd2)
        begin
            k_used = KW'(2);
        end
        else if (32'(k_period_reg) > 32'(MAX_K_PERIOD))
        begin
            k_used = KW'(MAX_K_PERIOD);
        end
        else
        begin
            k_used = KW'(k_period_reg);
        end
        if (d_period_reg < 5'd1)
        begin
            d_used = DW'(1);
        end
        else if (32'(d_period_reg) > 32'(MAX_D_PERIOD))
        begin
            d_used = DW'(MAX_D_PERIOD);
        end
        else
        begin
            d_used = DW'(d_period_reg);
        end
    end

    assign need = (min_samples_reg == 7'd0) ? NW'(k_used) : NW'(min_samples_reg);

    assign head_eff = (KW'(head_reg) >= k_used) ? '0 : head_reg;
    assign head_nx  = ((KW'(head_eff) + 1'b1) == k_used) ? '0 : KAW'(head_eff + 1'b1);
    assign fill_nx  = (fill_reg < k_used) ? KW'(fill_reg + 1'b1) : fill_reg;

    assign hhead_eff = (DW'(hhead_reg) >= d_used) ? '0 : hhead_reg;
    assign hhead_nx  = ((DW'(hhead_reg) + 1'b1) == d_used) ? '0 : DAW'(hhead_reg + 1'b1);
    assign hfill_nx  = (hfill_reg < d_used) ? DW'(hfill_reg + 1'b1) : hfill_reg;
    assign ksum_nx   = ksum_reg - KSW'(hist_old) + KSW'(kp_reg);

    assign cfg_clear = cfg_we && (cfg_index inside {REG_K_PERIOD, REG_D_PERIOD,
                       REG_MIN_SAMPLES, REG_OB_LEVEL, REG_OS_LEVEL});

    assign in_ready  = (state_reg == S_IDLE);
    assign accept_in = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign div_start = (state_reg == S_MUL) || (state_reg == S_HUPD && hfill_nx >= d_used);
    assign div_num   = (state_reg == S_MUL) ? NUM_W'(diff_reg) * NUM_W'(PCT_FULL)
                                            : NUM_W'(ksum_nx);
    assign div_den   = (state_reg == S_MUL) ? range_reg : DEN_W'(d_used);

    // Flags are only meaningful for a ready item; a not-ready item reports zeros.
    assign ob_now    = item_ready_reg && (kp_reg >= ob_level_reg);
    assign os_now    = item_ready_reg && (kp_reg <= os_level_reg);
    assign ob_ev_now = ob_now && !was_ob_reg;
    assign os_ev_now = os_now && !was_os_reg;
    assign above_now = kp_reg > lastd_reg;

    always_comb
    begin
        cross_now = CROSS_NONE;
        if (item_ready_reg && dready_reg)
        begin
            if (above_now && !was_above_reg)
            begin
                cross_now = CROSS_UP;
            end
            else if (!above_now && was_above_reg)
            begin
                cross_now = CROSS_DOWN;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = (NW'(fill_nx) >= need) ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = (win_hi == win_lo) ? S_HREAD : S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIVK;
            end
            S_DIVK:
            begin
                if (div_done)
                begin
                    state_next = S_HREAD;
                end
            end
            S_HREAD:
            begin
                state_next = S_HUPD;
            end
            S_HUPD:
            begin
                state_next = (hfill_nx >= d_used) ? S_DIVD : S_DONE;
            end
            S_DIVD:
            begin
                if (div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            k_period_reg    <= K_PERIOD_RST;
            d_period_reg    <= D_PERIOD_RST;
            min_samples_reg <= MIN_SAMPLES_RST;
            ob_level_reg    <= OB_LEVEL_RST;
            os_level_reg    <= OS_LEVEL_RST;
            head_reg        <= '0;
            fill_reg        <= '0;
            hhead_reg       <= '0;
            hfill_reg       <= '0;
            ksum_reg        <= '0;
            dready_reg      <= 1'b0;
            lastd_reg       <= '0;
            was_ob_reg      <= 1'b0;
            was_os_reg      <= 1'b0;
            was_above_reg   <= 1'b0;
            total_reg       <= '0;
            ob_total_reg    <= '0;
            os_total_reg    <= '0;
            item_ready_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (!cfg_clear && state_reg == S_DONE && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_clear)
            begin
                case (cfg_index)
                    REG_K_PERIOD:    k_period_reg    <= cfg_data[6:0];
                    REG_D_PERIOD:    d_period_reg    <= cfg_data[4:0];
                    REG_MIN_SAMPLES: min_samples_reg <= cfg_data[6:0];
                    REG_OB_LEVEL:    ob_level_reg    <= cfg_data;
                    REG_OS_LEVEL:    os_level_reg    <= cfg_data;
                    default:         ob_level_reg    <= ob_level_reg;
                endcase
                head_reg      <= '0;
                fill_reg      <= '0;
                hhead_reg     <= '0;
                hfill_reg     <= '0;
                ksum_reg      <= '0;
                dready_reg    <= 1'b0;
                lastd_reg     <= '0;
                was_ob_reg    <= 1'b0;
                was_os_reg    <= 1'b0;
                was_above_reg <= 1'b0;
                total_reg     <= '0;
                ob_total_reg  <= '0;
                os_total_reg  <= '0;
            end
            else
            begin
                case (state_reg)
                    S_WRITE:
                    begin
                        head_reg       <= head_nx;
                        fill_reg       <= fill_nx;
                        total_reg      <= total_reg + 1'b1;
                        item_ready_reg <= NW'(fill_nx) >= need;
                    end
                    S_HREAD:
                    begin
                        hhead_reg <= hhead_eff;
                    end
                    S_HUPD:
                    begin
                        ksum_reg  <= ksum_nx;
                        hhead_reg <= hhead_nx;
                        hfill_reg <= hfill_nx;
                    end
                    S_DIVD:
                    begin
                        if (div_done)
                        begin
                            lastd_reg  <= div_quot;
                            dready_reg <= 1'b1;
                        end
                    end
                    S_DONE:
                    begin
                        if (slot_free)
                        begin
                            if (item_ready_reg)
                            begin
                                was_ob_reg <= ob_now;
                                was_os_reg <= os_now;
                                if (ob_ev_now)
                                begin
                                    ob_total_reg <= ob_total_reg + 1'b1;
                                end
                                if (os_ev_now)
                                begin
                                    os_total_reg <= os_total_reg + 1'b1;
                                end
                                if (dready_reg)
                                begin
                                    was_above_reg <= above_now;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        head_reg <= head_reg;
                    end
                endcase
            end
        end
    end

    // Datapath registers of the item in flight.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x_reg <= sample;
        end
        if (state_reg == S_WRITE)
        begin
            kp_reg <= '0;
        end
        if (state_reg == S_SCAN && scan_done)
        begin
            range_reg <= DEN_W'(win_hi) - DEN_W'(win_lo);
            diff_reg  <= DEN_W'(x_reg) - DEN_W'(win_lo);
            kp_reg    <= PCT_HALF;
        end
        if (state_reg == S_DIVK && div_done)
        begin
            kp_reg <= div_quot;
        end
        if (state_reg == S_DONE && slot_free)
        begin
            ready_res_reg <= item_ready_reg;
            k_pct_reg     <= kp_reg;
            d_valid_reg   <= dready_reg;
            d_pct_reg     <= lastd_reg;
            ob_reg        <= ob_now;
            os_reg        <= os_now;
            ob_ev_reg     <= ob_ev_now;
            os_ev_reg     <= os_ev_now;
            cross_reg     <= cross_now;
            cnt_s_reg     <= total_reg;
            cnt_ob_reg    <= ob_total_reg + 32'(ob_ev_now);
            cnt_os_reg    <= os_total_reg + 32'(os_ev_now);
        end
    end

    sokd_window #(
        .MAX_K_PERIOD (MAX_K_PERIOD),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (state_reg == S_WRITE),
        .wr_addr    (head_eff),
        .wr_data    (x_reg),
        .scan_start (state_reg == S_WRITE),
        .scan_len   (fill_nx),
        .scan_done  (scan_done),
        .hi         (win_hi),
        .lo         (win_lo)
    );

    sokd_hist #(
        .MAX_D_PERIOD (MAX_D_PERIOD),
        .AW           (DAW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_clear),
        .rd_en   (state_reg == S_HREAD),
        .rd_addr (hhead_eff),
        .rd_data (hist_old),
        .wr_en   (state_reg == S_HUPD),
        .wr_addr (hhead_reg),
        .wr_data (kp_reg)
    );

    sokd_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid        = out_valid_reg;
    assign ready_res        = ready_res_reg;
    assign k_pct            = k_pct_reg;
    assign d_valid          = d_valid_reg;
    assign d_pct            = d_pct_reg;
    assign overbought       = ob_reg;
    assign oversold         = os_reg;
    assign overbought_event = ob_ev_reg;
    assign oversold_event   = os_ev_reg;
    assign crossing         = cross_reg;
    assign sample_count     = cnt_s_reg;
    assign overbought_count = cnt_ob_reg;
    assign oversold_count   = cnt_os_reg;

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k_used)
        else $error("window fill exceeds window length");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVK || state_reg == S_DIVD))
        else $error("divider finished outside a division state");

    a_kp_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> kp_reg <= PCT_FULL)
        else $error("%%K out of range");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_clear |=> (total_reg == 32'd0 && fill_reg == '0 && !dready_reg))
        else $error("configuration write did not clear state");

endmodule

// ----- src/sokd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in PCT_W bits. Depends on sokd_pkg.
module sokd_div #(
    parameter int DEN_W = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [DEN_W+sokd_pkg::PCT_W-1:0]    num,
    input  logic [DEN_W-1:0]                    den,
    output logic                                done,
    output logic [sokd_pkg::PCT_W-1:0]          quot
);
    import sokd_pkg::*;

    localparam int CW = $clog2(PCT_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [PCT_W-1:0] sh_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;

    assign trial = {rem_reg, sh_reg[PCT_W-1]};
    assign qbit  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(PCT_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DEN_W+PCT_W-1:PCT_W];
            sh_reg  <= num[PCT_W-1:0];
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            sh_reg  <= {sh_reg[PCT_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- src/sokd_window.sv -----
// Sample window memory with a sequential high/low scan over its first entries.
// One read per cycle, registered read data. Depends on sokd_pkg.
module sokd_window #(
    parameter int MAX_K_PERIOD = sokd_pkg::MAX_K_DEF,
    parameter int SAMPLE_WIDTH = sokd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [$clog2(MAX_K_PERIOD)-1:0]        wr_addr,
    input  logic signed [SAMPLE_WIDTH-1:0]         wr_data,
    input  logic                                   scan_start,
    input  logic [$clog2(MAX_K_PERIOD+1)-1:0]      scan_len,
    output logic                                   scan_done,
    output logic signed [SAMPLE_WIDTH-1:0]         hi,
    output logic signed [SAMPLE_WIDTH-1:0]         lo
);
    import sokd_pkg::*;

    localparam int AW = $clog2(MAX_K_PERIOD);
    localparam int LW = $clog2(MAX_K_PERIOD + 1);

    logic signed [SAMPLE_WIDTH-1:0] mem [MAX_K_PERIOD];
    logic signed [SAMPLE_WIDTH-1:0] rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] hi_reg;
    logic signed [SAMPLE_WIDTH-1:0] lo_reg;
    logic [AW-1:0] idx_reg;
    logic [LW-1:0] len_reg;
    logic          run_reg;
    logic          pend_reg;
    logic          last_reg;
    logic          first_reg;
    logic          done_reg;
    logic          at_end;

    assign at_end = (LW'(idx_reg) + 1'b1) == len_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (run_reg)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
            first_reg <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (scan_start)
            begin
                run_reg   <= 1'b1;
                pend_reg  <= 1'b0;
                first_reg <= 1'b1;
                idx_reg   <= '0;
                len_reg   <= scan_len;
            end
            else
            begin
                pend_reg <= run_reg;
                last_reg <= run_reg && at_end;
                if (run_reg)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (at_end)
                    begin
                        run_reg <= 1'b0;
                    end
                end
                if (pend_reg)
                begin
                    first_reg <= 1'b0;
                    if (last_reg)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            if (first_reg || rd_reg > hi_reg)
            begin
                hi_reg <= rd_reg;
            end
            if (first_reg || rd_reg < lo_reg)
            begin
                lo_reg <= rd_reg;
            end
        end
    end

    assign scan_done = done_reg;
    assign hi = hi_reg;
    assign lo = lo_reg;

endmodule

// ----- src/sokd_hist.sv -----
// %K history memory with per-entry valid bits; an entry not written since
// the last clear reads as zero. Depends on sokd_pkg.
module sokd_hist #(
    parameter int MAX_D_PERIOD = sokd_pkg::MAX_D_DEF,
    parameter int AW = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [sokd_pkg::PCT_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [sokd_pkg::PCT_W-1:0]  wr_data
);
    import sokd_pkg::*;

    logic [PCT_W-1:0]        mem [MAX_D_PERIOD];
    logic [MAX_D_PERIOD-1:0] vld_reg;
    logic [PCT_W-1:0]        rd_reg;
    logic                    rv_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else if (clear)
        begin
            vld_reg <= '0;
            rv_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rv_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rv_reg ? rd_reg : '0;

endmodule

// ----- tb/tb_stochastic_oscillator_kd.sv -----
// Testbench for the stochastic oscillator block: drives samples, predicts each
// result with a behavioral model and checks every field. Depends on sokd_pkg.
`timescale 1ns / 100ps

module tb_stochastic_oscillator_kd;
    import sokd_pkg::*;

    localparam int KMAX = 64;
    localparam int DMAX = 16;

    typedef struct packed {
        logic        rdy;
        logic [14:0] kp;
        logic        dv;
        logic [14:0] dp;
        logic        ob;
        logic        os;
        logic        obe;
        logic        ose;
        logic [1:0]  cr;
        logic [31:0] cnt;
        logic [31:0] obc;
        logic [31:0] osc;
    } osc_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [23:0] sample;
    logic out_valid;
    logic out_ready;
    logic ready_res;
    logic [14:0] k_pct;
    logic d_valid;
    logic [14:0] d_pct;
    logic overbought;
    logic oversold;
    logic overbought_event;
    logic oversold_event;
    logic [1:0] crossing;
    logic [31:0] sample_count;
    logic [31:0] overbought_count;
    logic [31:0] oversold_count;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stochastic_oscillator_kd uut (.*);

    // Predictor state: configuration and oscillator history.
    int unsigned k_cfg, d_cfg, min_cfg, ob_lvl, os_lvl;
    longint win [KMAX];
    int unsigned w_head, w_fill;
    int unsigned k_hist [DMAX];
    int unsigned h_head, h_fill, k_total, d_last;
    bit d_rdy, prev_ob, prev_os, prev_above;
    logic [31:0] n_samples, n_ob, n_os;

    logic signed [23:0] sample_queue [$];
    osc_result_t expected_results [$];
    int mismatches = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 74;
    bit send_hold = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic void clear_history();
        w_head = 0; w_fill = 0; h_head = 0; h_fill = 0; k_total = 0; d_last = 0;
        d_rdy = 0; prev_ob = 0; prev_os = 0; prev_above = 0;
        n_samples = 0; n_ob = 0; n_os = 0;
        for (int i = 0; i < DMAX; i++) k_hist[i] = 0;
    endfunction

    function automatic void model_write(cfg_reg_t idx, int unsigned val);
        case (idx)
            REG_K_PERIOD:    k_cfg = val & 'h7f;
            REG_D_PERIOD:    d_cfg = val & 'h1f;
            REG_MIN_SAMPLES: min_cfg = val & 'h7f;
            REG_OB_LEVEL:    ob_lvl = val & 'h7fff;
            REG_OS_LEVEL:    os_lvl = val & 'h7fff;
            default:         return;
        endcase
        clear_history();
    endfunction

    function automatic osc_result_t predict_oscillator(logic signed [23:0] x_in);
        osc_result_t r;
        int unsigned kk, dd, need;
        longint x, hi, lo, rng;
        longint unsigned kp;
        bit above;
        r = '0;
        kk = (k_cfg < 2) ? 2 : (k_cfg > KMAX) ? KMAX : k_cfg;
        dd = (d_cfg < 1) ? 1 : (d_cfg > DMAX) ? DMAX : d_cfg;
        need = (min_cfg == 0) ? kk : min_cfg;
        x = x_in;
        kp = 0;
        n_samples++;
        if (w_head >= kk) w_head = 0;
        win[w_head] = x;
        w_head = (w_head + 1) % kk;
        if (w_fill < kk) w_fill++;
        if (w_fill >= need) begin
            r.rdy = 1;
            hi = win[0]; lo = win[0];
            for (int i = 1; i < w_fill; i++) begin
                if (win[i] > hi) hi = win[i];
                if (win[i] < lo) lo = win[i];
            end
            rng = hi - lo;
            kp = (rng > 0) ? (64'd25600 * (x - lo)) / rng : 12800;
            if (h_head >= dd) h_head = 0;
            k_total = 32'(k_total - k_hist[h_head] + kp);
            k_hist[h_head] = 32'(kp);
            h_head = (h_head + 1) % dd;
            if (h_fill < dd) h_fill++;
            if (h_fill >= dd) begin
                d_last = k_total / dd;
                d_rdy = 1;
            end
            r.ob = kp >= ob_lvl;
            r.os = kp <= os_lvl;
            if (r.ob && !prev_ob) begin r.obe = 1; n_ob++; end
            if (r.os && !prev_os) begin r.ose = 1; n_os++; end
            prev_ob = r.ob;
            prev_os = r.os;
            if (d_rdy) begin
                above = kp > d_last;
                if (above && !prev_above) r.cr = CROSS_UP;
                else if (!above && prev_above) r.cr = CROSS_DOWN;
                prev_above = above;
            end
        end
        r.kp = kp[14:0];
        r.dv = d_rdy;
        r.dp = d_last[14:0];
        r.cnt = n_samples; r.obc = n_ob; r.osc = n_os;
        return r;
    endfunction

    // Sample driver; the predictor runs on each accepted request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_oscillator(sample));
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() > 0 && !send_hold
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    sample <= sample_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and random back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        osc_result_t got, want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (out_valid && out_ready)
            begin
                got = {ready_res, k_pct, d_valid, d_pct, overbought, oversold,
                       overbought_event, oversold_event, crossing, sample_count,
                       overbought_count, oversold_count};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    task automatic wait_drained();
        while (sample_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        model_write(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(int n);
        int mode;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(9);
            if (mode == 0)
                sample_queue.push_back($urandom_range(1) ? 24'h7fffff : 24'h800000);
            else if (mode < 4)
                sample_queue.push_back(24'($urandom()));
            else
                sample_queue.push_back(24'($signed(24'($urandom_range(40))) - 20));
        end
    endtask

    task automatic run_phase(int k, int d, int m, int ob, int os, int n);
        write_reg(REG_K_PERIOD, k);
        write_reg(REG_D_PERIOD, d);
        write_reg(REG_MIN_SAMPLES, m);
        write_reg(REG_OB_LEVEL, ob);
        write_reg(REG_OS_LEVEL, os);
        queue_random(n);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        k_cfg = 14; d_cfg = 3; min_cfg = 0; ob_lvl = 20480; os_lvl = 5120;
        clear_history();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, a run of equal samples, rising and falling runs at reset setup.
        sample_queue.push_back(24'h7fffff);
        sample_queue.push_back(24'h800000);
        for (int i = 0; i < 4; i++) sample_queue.push_back(24'd5);
        for (int i = 0; i < 8; i++) sample_queue.push_back(24'(i * 100));
        for (int i = 0; i < 8; i++) sample_queue.push_back(24'(-i * 100));
        sample_queue.push_back(24'h000000);
        sample_queue.push_back(24'hffffff);
        wait_drained();

        // Hold the sender mid-stream until every result has come back.
        queue_random(20);
        repeat (30) @(posedge clk);
        send_hold = 1;
        while (in_valid || expected_results.size() > 0)
            @(posedge clk);
        send_hold = 0;
        wait_drained();

        send_idle_pct = 10;
        recv_idle_pct = 74;
        run_phase(2, 1, 0, 25600, 0, 120);
        run_phase(64, 16, 64, 32767, 32767, 150);
        run_phase(5, 4, 80, 20000, 6000, 20);
        send_idle_pct = 74;
        recv_idle_pct = 10;
        run_phase(0, 0, 1, 0, 25600, 150);
        run_phase(127, 31, 3, 12800, 12800, 120);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(10, 5, 0, 18000, 7000, 250);
        run_phase(3, 2, 2, 15000, 10000, 200);

        if (mismatches == 0)
            $display("stochastic_oscillator_kd verification clean");
        else
            $display("stochastic_oscillator_kd verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("stochastic_oscillator_kd verification failed");
        $finish;
    end
endmodule

// ----- files.f -----
src/sokd_pkg.sv
src/sokd_div.sv
src/sokd_window.sv
src/sokd_hist.sv
src/stochastic_oscillator_kd.sv
tb/tb_stochastic_oscillator_kd.sv
